@@ design/roulette_wheel_pair_select_top_assert.svh @@
// Assertion macros for the roulette wheel pair selector.
// Used by rwps_checker; expects aclk and aresetn in scope.
`ifndef ROULETTE_WHEEL_PAIR_SELECT_TOP_ASSERT_SVH
`define ROULETTE_WHEEL_PAIR_SELECT_TOP_ASSERT_SVH

// same-cycle implication
`define RWPS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rwps_pkg.sv @@
// Shared types and constants for the roulette wheel pair selector.
// No dependencies.
`default_nettype none

package rwps_pkg;

    localparam int DEF_POP_SIZE     = 256;
    localparam int DEF_FITNESS_BITS = 32;
    localparam int OP_W             = 2;
    localparam int IN_FIT_W         = 32;
    localparam int RAND_W           = 32;
    localparam int INDEX_OUT_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 2'd0,
        OP_DRAW   = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM,
        ST_WALK,
        ST_FINISH
    } state_t;

    // per-cycle commands from the sequencer to each lane
    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic cmp;
    } lane_ctl_t;

endpackage

`default_nettype wire

@@ design/rwps_store.sv @@
// Fitness store: entry memory, fill count and running fitness total.
// Depends on rwps_pkg.
`default_nettype none

module rwps_store import rwps_pkg::*; #(
    parameter int POP_SIZE     = DEF_POP_SIZE,
    parameter int FITNESS_BITS = DEF_FITNESS_BITS,
    parameter int IDX_W        = $clog2(POP_SIZE),
    parameter int CNT_W        = $clog2(POP_SIZE + 1),
    parameter int TOTAL_BITS   = FITNESS_BITS + IDX_W
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    wr_en,
    input  wire logic [FITNESS_BITS-1:0] wr_data,
    input  wire logic                    clr,
    input  wire logic                    rd_en,
    input  wire logic [IDX_W-1:0]        rd_addr,
    output logic      [FITNESS_BITS-1:0] rd_data,
    output logic      [CNT_W-1:0]        count,
    output logic      [TOTAL_BITS-1:0]   total
);

    logic [FITNESS_BITS-1:0] fitness_mem [POP_SIZE];
    logic [FITNESS_BITS-1:0] rd_data_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [TOTAL_BITS-1:0]   total_reg, total_next;
    logic                    do_write;

    assign do_write = wr_en && (count_reg < CNT_W'(POP_SIZE));

    always_comb begin
        count_next = count_reg;
        total_next = total_reg;
        if (clr) begin
            count_next = '0;
            total_next = '0;
        end else if (do_write) begin
            count_next = count_reg + CNT_W'(1);
            total_next = total_reg + TOTAL_BITS'(wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            fitness_mem[count_reg[IDX_W-1:0]] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= fitness_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;
    assign total   = total_reg;

endmodule

`default_nettype wire

@@ design/rwps_lane.sv @@
// One selection lane: scales its random fraction onto the wheel and tracks
// the last entry whose interval holds that point. Depends on rwps_pkg.
`default_nettype none

module rwps_lane import rwps_pkg::*; #(
    parameter int TOTAL_BITS = DEF_FITNESS_BITS + 8,
    parameter int IDX_W      = 8
) (
    input  wire logic                  aclk,
    input  wire lane_ctl_t             ctl,
    input  wire logic [RAND_W-1:0]     rand_in,
    input  wire logic [TOTAL_BITS-1:0] total,
    input  wire logic [TOTAL_BITS-1:0] cmp_start,
    input  wire logic [TOTAL_BITS-1:0] cmp_end,
    input  wire logic [IDX_W-1:0]      cmp_idx,
    output logic      [IDX_W-1:0]      sel_idx
);

    localparam int HI_W  = (TOTAL_BITS > RAND_W) ? TOTAL_BITS - RAND_W : 1;
    localparam int EXT_W = RAND_W + HI_W;

    logic [EXT_W-1:0]      total_ext;
    logic [RAND_W-1:0]     tot_lo;
    logic [HI_W-1:0]       tot_hi;
    logic [RAND_W-1:0]     rand_reg;
    logic [2*RAND_W-1:0]   lo_prod_reg;
    logic [EXT_W-1:0]      hi_prod_reg;
    logic [TOTAL_BITS-1:0] point_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  hit;

    assign total_ext = EXT_W'(total);
    assign tot_lo    = total_ext[RAND_W-1:0];
    assign tot_hi    = total_ext[EXT_W-1:RAND_W];

    // point = r*hi + ((r*lo) >> 32), one partial product per cycle
    assign hit = (cmp_start <= point_reg) && (point_reg <= cmp_end);

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rand_reg <= rand_in;
        end
        if (ctl.mul_lo) begin
            lo_prod_reg <= (2*RAND_W)'(rand_reg) * (2*RAND_W)'(tot_lo);
        end
        if (ctl.mul_hi) begin
            hi_prod_reg <= EXT_W'(rand_reg) * EXT_W'(tot_hi);
        end
        if (ctl.sum) begin
            point_reg <= TOTAL_BITS'(hi_prod_reg)
                       + TOTAL_BITS'(lo_prod_reg[2*RAND_W-1:RAND_W]);
        end
        if (ctl.load) begin
            idx_reg <= '0;
        end else if (ctl.cmp && hit) begin
            idx_reg <= cmp_idx;
        end
    end

    assign sel_idx = idx_reg;

endmodule

`default_nettype wire

@@ design/roulette_wheel_pair_select_top.sv @@
// Roulette wheel parent-pair selector, top level: sequencer, two lanes,
// merge into the output register. Depends on rwps_pkg, rwps_store, rwps_lane.
//
// Usage:
//   Input channel s_*: one request per handshake. s_operation selects append
//   (store s_fitness_value, add it to the total), draw (pick two parents from
//   s_draw_a / s_draw_b) or clear. Code 3 is dropped. Appends past POP_SIZE
//   entries are dropped.
//   Output channel m_*: one result per draw request. m_pair_valid is 0 with
//   both indices 0 when the store is empty.
//   Append, clear and dropped requests are taken back to back.
//   A draw occupies the block through its steps: partial products and sum,
//   then a walk of the store through its registered read port (one read per
//   stored entry, the last compare, a drain step), both lanes comparing in
//   parallel, and then the load of the output register, which a draw on an
//   empty store goes to directly. The output register decouples the sides:
//   while a result waits, appends and clears are still taken; a finished draw
//   holds until m_ready frees it. Reset (aresetn low, synchronous) empties the
//   store and output; the entry memory needs no clearing pass.
`default_nettype none

module roulette_wheel_pair_select_top import rwps_pkg::*; #(
    parameter int POP_SIZE     = DEF_POP_SIZE,
    parameter int FITNESS_BITS = DEF_FITNESS_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [OP_W-1:0]        s_operation,
    input  wire logic [IN_FIT_W-1:0]    s_fitness_value,
    input  wire logic [RAND_W-1:0]      s_draw_a,
    input  wire logic [RAND_W-1:0]      s_draw_b,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [INDEX_OUT_W-1:0]      m_parent_a_index,
    output logic [INDEX_OUT_W-1:0]      m_parent_b_index,
    output logic                        m_pair_valid
);

    localparam int IDX_W      = $clog2(POP_SIZE);
    localparam int CNT_W      = $clog2(POP_SIZE + 1);
    localparam int TOTAL_BITS = FITNESS_BITS + IDX_W;

    state_t                  state_reg, state_next;
    lane_ctl_t               ctl;
    logic                    st_wr, st_clr, rd_en;
    logic [FITNESS_BITS-1:0] rd_data;
    logic [CNT_W-1:0]        count;
    logic [TOTAL_BITS-1:0]   total;
    logic [CNT_W-1:0]        issue_reg, issue_next;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    rd_vld_reg, rd_vld_next;
    logic [TOTAL_BITS-1:0]   start_reg, start_next, walk_end;
    logic [IDX_W-1:0]        sel_a, sel_b;
    logic                    out_load;
    logic                    m_valid_reg, m_valid_next;
    logic [INDEX_OUT_W-1:0]  a_idx_reg, b_idx_reg;
    logic                    pv_reg;

    rwps_store #(
        .POP_SIZE     (POP_SIZE),
        .FITNESS_BITS (FITNESS_BITS),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .TOTAL_BITS   (TOTAL_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st_wr),
        .wr_data (FITNESS_BITS'(s_fitness_value)),
        .clr     (st_clr),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .count   (count),
        .total   (total)
    );

    // interval of the entry now on the read data bus
    assign walk_end = start_reg + TOTAL_BITS'(rd_data);

    rwps_lane #(.TOTAL_BITS(TOTAL_BITS), .IDX_W(IDX_W)) u_lane_a (
        .aclk      (aclk),
        .ctl       (ctl),
        .rand_in   (s_draw_a),
        .total     (total),
        .cmp_start (start_reg),
        .cmp_end   (walk_end),
        .cmp_idx   (rd_idx_reg),
        .sel_idx   (sel_a)
    );

    rwps_lane #(.TOTAL_BITS(TOTAL_BITS), .IDX_W(IDX_W)) u_lane_b (
        .aclk      (aclk),
        .ctl       (ctl),
        .rand_in   (s_draw_b),
        .total     (total),
        .cmp_start (start_reg),
        .cmp_end   (walk_end),
        .cmp_idx   (rd_idx_reg),
        .sel_idx   (sel_b)
    );

    always_comb begin
        state_next  = state_reg;
        ctl         = '0;
        s_ready     = 1'b0;
        st_wr       = 1'b0;
        st_clr      = 1'b0;
        rd_en       = 1'b0;
        issue_next  = issue_reg;
        start_next  = start_reg;
        rd_vld_next = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (op_t'(s_operation))
                        OP_APPEND: st_wr  = 1'b1;
                        OP_CLEAR:  st_clr = 1'b1;
                        OP_DRAW: begin
                            ctl.load   = 1'b1;
                            state_next = (count == '0) ? ST_FINISH : ST_MUL_LO;
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL_LO: begin
                ctl.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                ctl.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                ctl.sum    = 1'b1;
                issue_next = '0;
                start_next = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                rd_en       = (issue_reg < count);
                rd_vld_next = rd_en;
                if (rd_en) begin
                    issue_next = issue_reg + CNT_W'(1);
                end
                if (rd_vld_reg) begin
                    ctl.cmp    = 1'b1;
                    start_next = walk_end;
                end
                if (!rd_en && !rd_vld_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        issue_reg <= issue_next;
        start_reg <= start_next;
        if (rd_en) begin
            rd_idx_reg <= issue_reg[IDX_W-1:0];
        end
        if (out_load) begin
            a_idx_reg <= INDEX_OUT_W'(sel_a);
            b_idx_reg <= INDEX_OUT_W'(sel_b);
            pv_reg    <= (count != '0);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_parent_a_index = a_idx_reg;
    assign m_parent_b_index = b_idx_reg;
    assign m_pair_valid     = pv_reg;

endmodule

`default_nettype wire

@@ design/rwps_checker.sv @@
// Port-level checks for the roulette wheel pair selector, bound to the top.
// Depends on rwps_pkg and roulette_wheel_pair_select_top_assert.svh.
`default_nettype none

`include "roulette_wheel_pair_select_top_assert.svh"

module rwps_checker import rwps_pkg::*; (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic [OP_W-1:0]        s_operation,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [INDEX_OUT_W-1:0] m_parent_a_index,
    input wire logic [INDEX_OUT_W-1:0] m_parent_b_index,
    input wire logic                   m_pair_valid
);

    // stalled result holds
    `RWPS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_parent_a_index) && $stable(m_parent_b_index) && $stable(m_pair_valid), "stalled result changed")

    // empty-store result carries zero indices
    `RWPS_ASSERT_SAME(a_empty_zero, m_valid && !m_pair_valid, m_parent_a_index == '0 && m_parent_b_index == '0, "empty draw with nonzero index")

    // a draw blocks the input in the cycle after acceptance
    `RWPS_ASSERT_NEXT(a_draw_busy, s_valid && s_ready && s_operation == OP_DRAW, !s_ready, "draw request did not block input")

    // non-draw requests leave the input ready in the next cycle
    `RWPS_ASSERT_NEXT(a_quick_ops, s_valid && s_ready && s_operation != OP_DRAW, s_ready, "non-draw request blocked input")

endmodule

bind roulette_wheel_pair_select_top rwps_checker u_rwps_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_operation      (s_operation),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_parent_a_index (m_parent_a_index),
    .m_parent_b_index (m_parent_b_index),
    .m_pair_valid     (m_pair_valid)
);

`default_nettype wire
